>>> hdl/two_pass_aa_stroke_blend_top_assert.svh
// Assertion macros for the two-pass stroke blend block.
// Used by two_pass_aa_stroke_blend_top; no other dependencies.
`ifndef TWO_PASS_AA_STROKE_BLEND_TOP_ASSERT_SVH
`define TWO_PASS_AA_STROKE_BLEND_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define TPSB_ASSERT_NOW(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define TPSB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define TPSB_ASSERT_NOW(lbl, clk, rst_n, cond, msg)

`define TPSB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/tpsb_pkg.sv
// Shared types and constants for the two-pass stroke blend block.
// No dependencies.
package tpsb_pkg;

  localparam int INSIDE_W = 24;
  localparam int PIX_W    = 32;
  localparam int HW_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DARK_COLOR        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_HALF_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_COLOR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_HALF_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH_SQUARED     = 3'd4;

  typedef struct packed {
    logic [INSIDE_W-1:0] inside_value;
    logic [PIX_W-1:0]    dest_pixel;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] new_pixel;
    logic             painted;
  } out_word_t;

endpackage

>>> hdl/two_pass_aa_stroke_blend_top.sv
// Top level of the two-pass antialiased stroke blend block.
// Uses tpsb_pkg, tpsb_isqrt, tpsb_over_pass and the assertion macro header.
//
// One pixel word is taken every clock cycle; busy never rises. Each word comes
// out on out_data with out_strobe high, in order. Each word passes through an
// input register, then the square-root pipeline, which resolves one root bit
// per stage, followed by coverage, alpha-scale and two multiply/divide stages
// per pass. Results cannot be held off. Configuration writes are always ready
// and take effect on words taken afterwards; write them only while no word is
// in flight.
`include "two_pass_aa_stroke_blend_top_assert.svh"

module two_pass_aa_stroke_blend_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  tpsb_pkg::in_word_t                  in_data,
  output logic                                out_strobe,
  output tpsb_pkg::out_word_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tpsb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpsb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ROOT_W  = (tpsb_pkg::INSIDE_W + FRAC_BITS + 1) / 2;
  localparam int SQ_W    = 2 * ROOT_W;
  localparam int CW      = ((ROOT_W > 17) ? ROOT_W : 17) + 1;
  localparam int COV_W   = FRAC_BITS + 1;
  localparam int SA_W    = FRAC_BITS + 8;
  localparam int ONE_I   = 1 << FRAC_BITS;
  localparam int HALF_I  = 1 << (FRAC_BITS - 1);
  localparam int SCALE_I = 255 << FRAC_BITS;
  localparam int TAG_W   = tpsb_pkg::PIX_W + 1;
  localparam int DTAG_W  = 2 + 2 * SA_W;
  localparam int LAT     = ROOT_W + 7;

  logic [31:0] dark_color_r;
  logic [15:0] dark_half_width_r;
  logic [31:0] bright_color_r;
  logic [15:0] bright_half_width_r;
  logic [23:0] reach_squared_r;

  logic        v0_r;
  logic [23:0] d2_r;
  logic [31:0] pix0_r;
  logic        painted0_r;
  logic [23:0] d2_nxt;

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [TAG_W-1:0]  sq_tag;

  logic [CW-1:0]    dist_w;
  logic [CW-1:0]    sum_dark;
  logic [CW-1:0]    sum_bright;
  logic [COV_W-1:0] cov_dark_nxt;
  logic [COV_W-1:0] cov_bright_nxt;
  logic             v1_r;
  logic [COV_W-1:0] cov_dark_r;
  logic [COV_W-1:0] cov_bright_r;
  logic [TAG_W-1:0] tag1_r;

  logic [SA_W-1:0]  sa_dark_nxt;
  logic [SA_W-1:0]  sa_bright_nxt;
  logic             v2_r;
  logic [SA_W-1:0]  sa_dark_r;
  logic [SA_W-1:0]  keep_dark_r;
  logic             en_dark_r;
  logic [SA_W-1:0]  sa_bright_r;
  logic [SA_W-1:0]  keep_bright_r;
  logic             en_bright_r;
  logic [TAG_W-1:0] tag2_r;

  logic              dp_valid;
  logic [31:0]       dp_pixel;
  logic [DTAG_W-1:0] dp_tag;
  logic              bp_valid;
  logic [31:0]       bp_pixel;
  logic              bp_tag;

  function automatic logic [COV_W-1:0] coverage(input logic [CW-1:0] sum,
                                                 input logic [CW-1:0] root_dist);
    logic [CW-1:0] diff;
    diff = sum - root_dist;
    if (root_dist >= sum) begin
      return '0;
    end else if (diff > CW'(ONE_I)) begin
      return COV_W'(ONE_I);
    end else begin
      return diff[COV_W-1:0];
    end
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_color_r        <= '0;
      dark_half_width_r   <= '0;
      bright_color_r      <= '0;
      bright_half_width_r <= '0;
      reach_squared_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tpsb_pkg::CFG_DARK_COLOR: begin
          dark_color_r <= cfg_data;
        end
        tpsb_pkg::CFG_DARK_HALF_WIDTH: begin
          dark_half_width_r <= cfg_data[15:0];
        end
        tpsb_pkg::CFG_BRIGHT_COLOR: begin
          bright_color_r <= cfg_data;
        end
        tpsb_pkg::CFG_BRIGHT_HALF_WIDTH: begin
          bright_half_width_r <= cfg_data[15:0];
        end
        tpsb_pkg::CFG_REACH_SQUARED: begin
          reach_squared_r <= cfg_data[23:0];
        end
        default: begin
        end
      endcase
    end
  end

  // squared distance, clamped at zero
  assign d2_nxt = (reach_squared_r > in_data.inside_value) ?
                  (reach_squared_r - in_data.inside_value) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= sq_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    d2_r       <= d2_nxt;
    pix0_r     <= in_data.dest_pixel;
    painted0_r <= (in_data.inside_value != '0);
  end

  tpsb_isqrt #(
    .ROOT_W (ROOT_W),
    .TAG_W  (TAG_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v0_r),
    .in_x      (SQ_W'(d2_r) << FRAC_BITS),
    .in_tag    ({painted0_r, pix0_r}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  assign dist_w         = CW'(sq_root);
  assign sum_dark       = CW'(dark_half_width_r) + CW'(HALF_I);
  assign sum_bright     = CW'(bright_half_width_r) + CW'(HALF_I);
  assign cov_dark_nxt   = coverage(sum_dark, dist_w);
  assign cov_bright_nxt = coverage(sum_bright, dist_w);

  always_ff @(posedge clk) begin
    cov_dark_r   <= cov_dark_nxt;
    cov_bright_r <= cov_bright_nxt;
    tag1_r       <= sq_tag;
  end

  assign sa_dark_nxt   = SA_W'(dark_color_r[31:24]) * SA_W'(cov_dark_r);
  assign sa_bright_nxt = SA_W'(bright_color_r[31:24]) * SA_W'(cov_bright_r);

  always_ff @(posedge clk) begin
    sa_dark_r     <= sa_dark_nxt;
    keep_dark_r   <= SA_W'(SCALE_I) - sa_dark_nxt;
    en_dark_r     <= tag1_r[TAG_W-1] && (dark_half_width_r != '0) && (sa_dark_nxt != '0);
    sa_bright_r   <= sa_bright_nxt;
    keep_bright_r <= SA_W'(SCALE_I) - sa_bright_nxt;
    en_bright_r   <= tag1_r[TAG_W-1] && (bright_half_width_r != '0)
                     && (sa_bright_nxt != '0);
    tag2_r        <= tag1_r;
  end

  tpsb_over_pass #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (DTAG_W)
  ) u_dark_pass (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_pixel  (tag2_r[31:0]),
    .in_en     (en_dark_r),
    .in_sa     (sa_dark_r),
    .in_keep   (keep_dark_r),
    .in_rgb    (dark_color_r[23:0]),
    .in_tag    ({tag2_r[TAG_W-1], en_bright_r, sa_bright_r, keep_bright_r}),
    .out_valid (dp_valid),
    .out_pixel (dp_pixel),
    .out_tag   (dp_tag)
  );

  tpsb_over_pass #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (1)
  ) u_bright_pass (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dp_valid),
    .in_pixel  (dp_pixel),
    .in_en     (dp_tag[DTAG_W-2]),
    .in_sa     (dp_tag[2*SA_W-1:SA_W]),
    .in_keep   (dp_tag[SA_W-1:0]),
    .in_rgb    (bright_color_r[23:0]),
    .in_tag    (dp_tag[DTAG_W-1]),
    .out_valid (bp_valid),
    .out_pixel (bp_pixel),
    .out_tag   (bp_tag)
  );

  assign out_strobe         = bp_valid;
  assign out_data.new_pixel = bp_pixel;
  assign out_data.painted   = bp_tag;

  `TPSB_ASSERT_IMPL(a_strobe_latency, clk, rst_n, out_strobe, $past(start && !busy, LAT), "result word without an accepted word at fixed latency")
  `TPSB_ASSERT_IMPL(a_unpainted_passthru, clk, rst_n, out_strobe && !out_data.painted, out_data.new_pixel == $past(in_data.dest_pixel, LAT), "unpainted word did not pass through")
  `TPSB_ASSERT_IMPL(a_painted_source, clk, rst_n, out_strobe && out_data.painted, $past(in_data.inside_value, LAT) != '0, "painted flag set for a zero inside value")

endmodule

>>> hdl/tpsb_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Carries a side tag and a valid bit along with each word; no package use.
module tpsb_isqrt #(
  parameter int ROOT_W = 16,
  parameter int TAG_W  = 33
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] in_x,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   out_root,
  output logic [TAG_W-1:0]    out_tag
);

  localparam int SQ_W  = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              v_r    [ROOT_W];
  logic [SQ_W-1:0]   x_r    [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [TAG_W-1:0]  tag_r  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              v_prev;
    logic [SQ_W-1:0]   x_prev;
    logic [REM_W-1:0]  rem_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [TAG_W-1:0]  tag_prev;
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  trial;
    logic              take;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (i == 0) begin : g_first
      assign v_prev    = in_valid;
      assign x_prev    = in_x;
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign tag_prev  = in_tag;
    end else begin : g_next
      assign v_prev    = v_r[i-1];
      assign x_prev    = x_r[i-1];
      assign rem_prev  = rem_r[i-1];
      assign root_prev = root_r[i-1];
      assign tag_prev  = tag_r[i-1];
    end

    assign rem_in   = {rem_prev[ROOT_W-1:0], x_prev[SQ_W-1 -: 2]};
    assign trial    = {root_prev, 2'b01};
    assign take     = (rem_in >= trial);
    assign rem_nxt  = take ? (rem_in - trial) : rem_in;
    assign root_nxt = {root_prev[ROOT_W-2:0], take};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      x_r[i]    <= x_prev << 2;
      rem_r[i]  <= rem_nxt;
      root_r[i] <= root_nxt;
      tag_r[i]  <= tag_prev;
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_tag   = tag_r[ROOT_W-1];

endmodule

>>> hdl/tpsb_over_pass.sv
// One premultiplied OVER pass over an ARGB32 pixel, two register stages.
// Multiply-accumulate per channel, then round, divide by 255 and saturate.
module tpsb_over_pass #(
  parameter int FRAC_BITS = 8,
  parameter int TAG_W     = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [31:0]          in_pixel,
  input  logic                 in_en,
  input  logic [FRAC_BITS+7:0] in_sa,
  input  logic [FRAC_BITS+7:0] in_keep,
  input  logic [23:0]          in_rgb,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output logic [31:0]          out_pixel,
  output logic [TAG_W-1:0]     out_tag
);

  localparam int ACC_W   = FRAC_BITS + 16;
  localparam int HALF_SI = 255 << (FRAC_BITS - 1);

  logic [7:0]       src [4];
  logic [7:0]       dst [4];
  logic [ACC_W-1:0] acc_nxt [4];
  logic [ACC_W-1:0] acc_r   [4];
  logic [31:0]      pix_r;
  logic             en_r;
  logic             v1_r;
  logic [TAG_W-1:0] tag1_r;
  logic [7:0]       q     [4];
  logic [31:0]      pixel_nxt;
  logic             v2_r;
  logic [31:0]      pixel_r;
  logic [TAG_W-1:0] tag2_r;

  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [15:0] t;
    logic [7:0]  q0;
    logic [16:0] rem;
    logic [8:0]  qf;
    t   = y + (y >> 8);
    q0  = t[15:8];
    rem = {1'b0, y} - ({9'b0, q0} * 17'd255);
    qf  = {1'b0, q0} + ((rem >= 17'd255) ? 9'd1 : 9'd0);
    return (qf > 9'd255) ? 8'd255 : qf[7:0];
  endfunction

  assign src[3] = 8'd255;
  assign src[2] = in_rgb[23:16];
  assign src[1] = in_rgb[15:8];
  assign src[0] = in_rgb[7:0];
  assign dst[3] = in_pixel[31:24];
  assign dst[2] = in_pixel[23:16];
  assign dst[1] = in_pixel[15:8];
  assign dst[0] = in_pixel[7:0];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign acc_nxt[k] = ACC_W'(src[k]) * ACC_W'(in_sa) + ACC_W'(dst[k]) * ACC_W'(in_keep)
                        + ACC_W'(HALF_SI);
    assign q[k] = div255(acc_r[k][ACC_W-1:FRAC_BITS]);
  end

  assign pixel_nxt = en_r ? {q[3], q[2], q[1], q[0]} : pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      acc_r[k] <= acc_nxt[k];
    end
    pix_r   <= in_pixel;
    en_r    <= in_en;
    tag1_r  <= in_tag;
    pixel_r <= pixel_nxt;
    tag2_r  <= tag1_r;
  end

  assign out_valid = v2_r;
  assign out_pixel = pixel_r;
  assign out_tag   = tag2_r;

endmodule
